@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the PLL register programmer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, ignored while reset is held.
`define PRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge.
`define PRP_NEVER(lbl, expr, msg) \
    `PRP_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/pllrp_pkg.sv @@
// Types, constants and sequence tables of the PLL synthesizer register programmer.
package pllrp_pkg;

    // Command codes carried in the opcode field.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_PROG_ALL  = 3'd1;
    localparam logic [2:0] OP_SET_FREQ  = 3'd2;
    localparam logic [2:0] OP_SET_POWER = 3'd3;
    localparam logic [2:0] OP_CHIP      = 3'd4;
    localparam logic [2:0] OP_RF_OUT    = 3'd5;

    localparam int unsigned NUM_REGS = 6;

    // Bus timing: 64 ticks of data, then one gap tick, two latch ticks and one idle tick.
    localparam logic [6:0] DATA_TICKS    = 7'd64;
    localparam logic [6:0] LATCH_FIRST   = 7'd65;
    localparam logic [6:0] LATCH_LAST    = 7'd66;
    localparam logic [6:0] TICKS_PER_REG = 7'd68;

    localparam logic [31:0] POWER_UP_WORDS [NUM_REGS] = '{
        32'h0070_0000, 32'h0800_0009, 32'h1800_5EC2,
        32'h0000_04B3, 32'h00C5_0004, 32'h0048_0005
    };

    localparam logic [31:0] REG0_KEEP_MASK  = 32'h8000_0007;
    localparam logic [31:0] REG1_KEEP_MASK  = 32'h0800_0007;
    localparam logic [31:0] REG1_MOD_ONE    = 32'h0000_0008;
    localparam logic [31:0] DIV_KEEP_MASK   = 32'hFF8F_FFFF;
    localparam logic [31:0] POWER_KEEP_MASK = 32'hFFFF_FFE7;
    localparam logic [31:0] BIT5_KEEP_MASK  = 32'hFFFF_FFDF;

    // Lowest input frequency for each output divider that keeps the VCO at or above 2200 MHz.
    localparam logic [22:0] VCO_MIN_DIV1 = 23'd2_200_000;
    localparam logic [22:0] VCO_MIN_DIV2 = 23'd1_100_000;
    localparam logic [22:0] VCO_MIN_DIV4 = 23'd550_000;
    localparam logic [22:0] VCO_MIN_DIV8 = 23'd275_000;

    // x / 10000 for x below 2^23 is ((x >> 4) * RECIP_625) >> RECIP_SHIFT, exact.
    localparam logic [19:0] RECIP_625   = 20'd858_994;
    localparam int unsigned RECIP_SHIFT = 29;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [22:0] freq_khz;
        logic [3:0]  power_level;
        logic        switch_on;
    } cmd_t;

    typedef struct packed {
        logic pin_enable;
        logic pin_data;
        logic pin_clock;
        logic pin_latch;
        logic busy_res;
        logic command_taken;
    } res_t;

    // Number of register words that a command sends.
    function automatic logic [2:0] seq_length(input logic [2:0] kind);
        logic [2:0] len;
        unique case (kind) inside
            OP_PROG_ALL:                     len = 3'd6;
            OP_SET_FREQ:                     len = 3'd3;
            OP_SET_POWER, OP_CHIP, OP_RF_OUT: len = 3'd1;
            default:                         len = 3'd0;
        endcase
        return len;
    endfunction

    // Shadow register sent at a given place of a command's sequence.
    function automatic logic [2:0] seq_reg_index(input logic [2:0] kind,
                                                 input logic [2:0] pos);
        logic [2:0] idx;
        unique case (kind) inside
            OP_PROG_ALL:
            begin
                idx = 3'd5 - pos;
            end
            OP_SET_FREQ:
            begin
                unique case (pos)
                    3'd0:    idx = 3'd4;
                    3'd1:    idx = 3'd1;
                    default: idx = 3'd0;
                endcase
            end
            OP_SET_POWER, OP_RF_OUT:
            begin
                idx = 3'd4;
            end
            OP_CHIP:
            begin
                idx = 3'd2;
            end
            default:
            begin
                idx = 3'd0;
            end
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/pll_synth_register_programmer.sv @@
// A command passes through the input register and then the result register, where its result waits.
// Throughput: one item per cycle while the output is not stalled; a tick item yields one bus pin state.
// Each register word takes 68 tick items on the bus; a command is accepted only while idle.
// Reset (rst_n, asynchronous, active low) loads the six power-up words and clears the sequencer.
// No clearing pass is needed: the block can take a transfer as soon as reset is released.
module pll_synth_register_programmer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  pllrp_pkg::cmd_t  cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output pllrp_pkg::res_t  res
);

    import pllrp_pkg::*;

    `include "assert_macros.svh"

    // Input register: holds the accepted command until the result stage can take it.
    logic cmd_valid_reg, cmd_valid_next;
    cmd_t cmd_reg;

    // Result register.
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    // Shadow copies of the synthesizer registers and the shift sequencer state.
    logic [31:0] shadow_reg [NUM_REGS];
    logic [31:0] shadow_next [NUM_REGS];
    logic [6:0]  tick_index_reg, tick_index_next;
    logic [2:0]  send_pos_reg, send_pos_next;
    logic [2:0]  send_kind_reg, send_kind_next;
    logic        sending_reg, sending_next;

    // Handshake control.
    logic advance;
    logic fire;

    // Datapath helpers.
    logic [2:0]  word_idx;
    logic [31:0] cur_word;
    logic [2:0]  div_code;
    logic [22:0] vco_khz;
    logic [38:0] recip_prod;
    logic [15:0] int_val;
    logic [1:0]  power_sat;

    // The result stage moves whenever its register is empty or being drained. A result
    // waiting at the output holds the command in the input register, and the input side
    // can then take one more command only while that register is empty.
    assign advance   = !res_valid_reg || res_ready;
    assign fire      = cmd_valid_reg && advance;
    assign cmd_ready = !cmd_valid_reg || advance;

    always_comb
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (fire)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    assign res_valid_next = advance ? cmd_valid_reg : res_valid_reg;

    // Shadow register index and word currently on the bus.
    assign word_idx = seq_reg_index(send_kind_reg, send_pos_reg);
    assign cur_word = shadow_reg[word_idx];

    // Output divider: the smallest power of two that brings the VCO to 2200 MHz,
    // saturating at 16 for very low frequencies.
    always_comb
    begin
        if (cmd_reg.freq_khz >= VCO_MIN_DIV1)
        begin
            div_code = 3'd0;
        end
        else if (cmd_reg.freq_khz >= VCO_MIN_DIV2)
        begin
            div_code = 3'd1;
        end
        else if (cmd_reg.freq_khz >= VCO_MIN_DIV4)
        begin
            div_code = 3'd2;
        end
        else if (cmd_reg.freq_khz >= VCO_MIN_DIV8)
        begin
            div_code = 3'd3;
        end
        else
        begin
            div_code = 3'd4;
        end
    end

    // For a divided input the thresholds keep the shifted value below 4.4 GHz; it always fits in 23 bits.
    assign vco_khz    = cmd_reg.freq_khz << div_code;
    // Division by 10000 as a multiply by the reciprocal of 625 after dropping four bits.
    assign recip_prod = 39'(vco_khz[22:4]) * 39'(RECIP_625);
    assign int_val    = 16'(recip_prod[38:RECIP_SHIFT]);
    assign power_sat  = (cmd_reg.power_level > 4'd3) ? 2'd3 : cmd_reg.power_level[1:0];

    // Next state and result for the command in the input register.
    always_comb
    begin
        shadow_next     = shadow_reg;
        tick_index_next = tick_index_reg;
        send_pos_next   = send_pos_reg;
        send_kind_next  = send_kind_reg;
        sending_next    = sending_reg;
        res_next        = '0;

        if (fire)
        begin
            if (cmd_reg.opcode == OP_TICK)
            begin
                if (sending_reg)
                begin
                    if (tick_index_reg < DATA_TICKS)
                    begin
                        // Two ticks per bit, MSB first; the clock rises on the second.
                        res_next.pin_enable = 1'b1;
                        res_next.pin_data   = cur_word[~tick_index_reg[5:1]];
                        res_next.pin_clock  = tick_index_reg[0];
                    end
                    else if (tick_index_reg == DATA_TICKS)
                    begin
                        res_next.pin_enable = 1'b1;
                    end
                    else if (tick_index_reg == LATCH_FIRST || tick_index_reg == LATCH_LAST)
                    begin
                        res_next.pin_enable = 1'b1;
                        res_next.pin_latch  = 1'b1;
                    end

                    if (tick_index_reg == TICKS_PER_REG - 7'd1)
                    begin
                        tick_index_next = '0;
                        if (send_pos_reg + 3'd1 >= seq_length(send_kind_reg))
                        begin
                            send_pos_next = '0;
                            sending_next  = 1'b0;
                        end
                        else
                        begin
                            send_pos_next = send_pos_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        tick_index_next = tick_index_reg + 7'd1;
                    end
                end
            end
            else if (cmd_reg.opcode <= OP_RF_OUT && !sending_reg)
            begin
                res_next.command_taken = 1'b1;
                case (cmd_reg.opcode)
                    OP_SET_FREQ:
                    begin
                        // INT from the divided VCO, FRAC cleared and MOD set to one.
                        shadow_next[0] = (shadow_reg[0] & REG0_KEEP_MASK)
                                       | (32'(int_val) << 15);
                        shadow_next[1] = (shadow_reg[1] & REG1_KEEP_MASK) | REG1_MOD_ONE;
                        shadow_next[4] = (shadow_reg[4] & DIV_KEEP_MASK)
                                       | (32'(div_code) << 20);
                    end
                    OP_SET_POWER:
                    begin
                        shadow_next[4] = (shadow_reg[4] & POWER_KEEP_MASK)
                                       | (32'(power_sat) << 3);
                    end
                    OP_CHIP:
                    begin
                        // The chip register holds a power-down bit, hence the inversion.
                        shadow_next[2] = (shadow_reg[2] & BIT5_KEEP_MASK)
                                       | (32'(!cmd_reg.switch_on) << 5);
                    end
                    OP_RF_OUT:
                    begin
                        shadow_next[4] = (shadow_reg[4] & BIT5_KEEP_MASK)
                                       | (32'(cmd_reg.switch_on) << 5);
                    end
                    default:
                    begin
                    end
                endcase
                send_kind_next  = cmd_reg.opcode;
                send_pos_next   = '0;
                tick_index_next = '0;
                sending_next    = 1'b1;
            end
            // Unused codes and commands that arrive while busy change nothing.
            res_next.busy_res = sending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            shadow_reg     <= POWER_UP_WORDS;
            tick_index_reg <= '0;
            send_pos_reg   <= '0;
            send_kind_reg  <= '0;
            sending_reg    <= 1'b0;
        end
        else
        begin
            cmd_valid_reg  <= cmd_valid_next;
            res_valid_reg  <= res_valid_next;
            shadow_reg     <= shadow_next;
            tick_index_reg <= tick_index_next;
            send_pos_reg   <= send_pos_next;
            send_kind_reg  <= send_kind_next;
            sending_reg    <= sending_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The tick counter never runs past the end of a register word.
    `PRP_NEVER(a_tick_range, tick_index_reg >= TICKS_PER_REG, "tick index out of range")

    // An idle sequencer always sits at the start of a sequence.
    `PRP_NEVER(a_idle_at_start,
               !sending_reg && (tick_index_reg != '0 || send_pos_reg != '0),
               "idle sequencer not rewound")

    // A taken command always starts a sequence.
    `PRP_ASSERT(a_taken_busy,
                res_valid_reg && res_reg.command_taken |-> res_reg.busy_res,
                "taken command without busy")

    // The latch line is only driven inside an enabled frame.
    `PRP_NEVER(a_latch_in_frame,
               res_valid_reg && res_reg.pin_latch && !res_reg.pin_enable,
               "latch without enable")

endmodule
